/* hw/rtl/snooping_coherence_bus_unit_macros.svh */
// assertion macros for the snooping coherence bus unit
// used by files that check their own logic; needs clk and rst_n in scope
`ifndef SNOOPING_COHERENCE_BUS_UNIT_MACROS_SVH
`define SNOOPING_COHERENCE_BUS_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define SCBU_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scbu assertion failed");
// antecedent implies consequent in the next cycle
`define SCBU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scbu assertion failed");
`else
`define SCBU_ASSERT_NOW(lbl, ante, cons)
`define SCBU_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* hw/rtl/scbu_pkg.sv */
// types and constants of the snooping coherence bus unit
// no dependencies; imported by scbu_ram users and the top level
`timescale 1ns / 1ps
`default_nettype none

package scbu_pkg;

  localparam int ADDR_W     = 16;
  localparam int DATA_W     = 32;
  localparam int LSTATE_W   = 3;
  localparam int SRC_W      = 2;
  localparam int SRC_CACHE_W = 2;
  localparam int INVAL_W    = 5;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef enum logic [LSTATE_W-1:0] {
    LS_I = 3'd0,
    LS_S = 3'd1,
    LS_E = 3'd2,
    LS_O = 3'd3,
    LS_M = 3'd4
  } line_state_t;

  typedef enum logic [SRC_W-1:0] {
    SRC_LOCAL = 2'd0,
    SRC_PEER  = 2'd1,
    SRC_MEM   = 2'd2,
    SRC_WRITE = 2'd3
  } src_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_OWN,
    ST_SCAN,
    ST_FILL,
    ST_DONE
  } scbu_state_t;

  typedef struct packed {
    logic [0:0]        operation;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] write_data;
    logic [1:0]        requester;
    logic [2:0]        block;
    logic [DATA_W-1:0] memory_word;
  } in_req_t;

  typedef struct packed {
    logic [DATA_W-1:0]      read_data;
    logic [SRC_W-1:0]       source;
    logic [SRC_CACHE_W-1:0] source_cache;
    logic [INVAL_W-1:0]     invalidated;
    logic [LSTATE_W-1:0]    new_state;
  } out_res_t;

  // one cache block as kept in the block store
  typedef struct packed {
    logic [ADDR_W-1:0]   tag;
    logic [DATA_W-1:0]   data;
    logic [LSTATE_W-1:0] lstate;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

/* hw/rtl/scbu_ram.sv */
// generic simple dual port ram, one write and one registered read per cycle
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module scbu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* hw/rtl/snooping_coherence_bus_unit.sv */
// snooping coherence bus unit: top level, sequencer and coherence datapath
// depends on scbu_pkg, scbu_ram and snooping_coherence_bus_unit_macros.svh
//
// usage
//   input channel (in_valid / in_stall / in_payload) carries one read or write
//   transaction for one block of one cache; the result channel
//   (out_valid / out_stall / out_payload) returns exactly one result each.
//   cfg_valid / cfg_ready / cfg_protocol_mode writes the protocol mode
//   (0 moesi, 1 mesi); cfg_ready is always high, write only while idle.
// sequence, P = (NUM_CACHES - 1) * BLOCKS_PER_CACHE peer blocks (24 by default)
//   local read hit: own block read, then the result
//   read miss or write: own block, then a scan of the P peer blocks; a read
//   ends at its first peer hit; one transaction at a time, none taken before
//   the last result is in the output register; the scan goes through the single read
//   port of the block store, one peer block per cycle
// reset
//   synchronous, active low; afterwards a clearing pass over all
//   NUM_CACHES * BLOCKS_PER_CACHE blocks (32 by default) zeroes tags, data
//   and line states while in_stall stays high
// stall
//   a finished result waits in the output register while out_stall is high;
//   the next transaction is still accepted and completes up to its result
`timescale 1ns / 1ps
`default_nettype none
`include "snooping_coherence_bus_unit_macros.svh"

module snooping_coherence_bus_unit
  import scbu_pkg::*;
#(
  parameter int NUM_CACHES       = 4,
  parameter int BLOCKS_PER_CACHE = 8
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  // request transactions
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_req_t  in_payload,
  // result transactions
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_res_t      out_payload,
  // protocol mode register
  input  wire logic     cfg_valid,
  output logic          cfg_ready,
  input  wire logic     cfg_protocol_mode
);

  localparam int NBLK  = NUM_CACHES * BLOCKS_PER_CACHE;
  localparam int IDX_W = $clog2(NBLK);
  localparam int CW    = $clog2(NUM_CACHES);
  localparam int BW    = (BLOCKS_PER_CACHE > 1) ? $clog2(BLOCKS_PER_CACHE) : 1;

  // narrow modulo by repeated conditional subtract (operands are a few bits)
  function automatic int unsigned mod_small(int unsigned v, int unsigned m);
    int unsigned r;
    r = v;
    for (int i = 0; i < 8; i++) begin
      if (r >= m) begin
        r = r - m;
      end
    end
    return r;
  endfunction

  function automatic logic is_valid_state(logic [LSTATE_W-1:0] s);
    logic v;
    case (s) inside
      LS_S, LS_E, LS_O, LS_M: v = 1'b1;
      default:                v = 1'b0;
    endcase
    return v;
  endfunction

  // requester block state after a write
  function automatic logic [LSTATE_W-1:0] write_next(logic [LSTATE_W-1:0] s, logic mesi);
    logic [LSTATE_W-1:0] n;
    case (s)
      LS_S:    n = LS_M;
      LS_I:    n = mesi ? LS_E : LS_O;
      default: n = s;
    endcase
    return n;
  endfunction

  // supplying peer state after a read it served
  function automatic logic [LSTATE_W-1:0] peer_next(logic [LSTATE_W-1:0] s, logic mesi);
    logic [LSTATE_W-1:0] n;
    if (!mesi && (s == LS_E || s == LS_O)) begin
      n = LS_O;
    end else begin
      n = LS_S;
    end
    return n;
  endfunction

  // control registers
  scbu_state_t      state_r, state_nxt;
  logic             mode_r, mode_nxt;
  logic [IDX_W-1:0] clr_r, clr_nxt;
  logic             issue_left_r, issue_left_nxt;
  logic             chk_v_r, chk_v_nxt;
  logic             out_valid_r, out_valid_nxt;

  // transaction and scan registers
  logic              op_r, op_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [DATA_W-1:0] wdata_r, wdata_nxt;
  logic [DATA_W-1:0] mem_r, mem_nxt;
  logic [CW-1:0]     req_r, req_nxt;
  logic [IDX_W-1:0]  me_r, me_nxt;
  logic [CW-1:0]     scan_c_r, scan_c_nxt;
  logic [BW-1:0]     scan_b_r, scan_b_nxt;
  logic [IDX_W-1:0]  chk_idx_r, chk_idx_nxt;
  logic [CW-1:0]     chk_c_r, chk_c_nxt;
  logic [INVAL_W-1:0] inval_r, inval_nxt;
  logic [IDX_W-1:0]  pe_idx_r, pe_idx_nxt;
  entry_t            pe_entry_r, pe_entry_nxt;
  out_res_t          res_r, res_nxt;
  out_res_t          out_payload_r, out_payload_nxt;

  // block store port
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  entry_t             ram_wdata;
  logic [IDX_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t             rd;

  // derived values
  logic [CW-1:0]    req_now;
  logic [BW-1:0]    blk_now;
  logic [IDX_W-1:0] me_now;
  logic [CW-1:0]    c_first;
  logic [IDX_W-1:0] peer_idx;
  logic [CW-1:0]    c_next;
  logic             scan_last;
  logic             clr_last;
  logic             in_accept;
  logic             out_free;
  logic             peer_hit;
  logic             own_hit;

  assign rd = entry_t'(ram_rdata);

  assign req_now = CW'(mod_small(32'(in_payload.requester), NUM_CACHES));
  assign blk_now = BW'(mod_small(32'(in_payload.block), BLOCKS_PER_CACHE));
  assign me_now  = IDX_W'(32'(req_now) * BLOCKS_PER_CACHE + 32'(blk_now));
  assign c_first = (req_now == '0) ? CW'(1) : '0;

  assign peer_idx = IDX_W'(32'(scan_c_r) * BLOCKS_PER_CACHE + 32'(scan_b_r));

  // next peer cache, stepping over the requester
  always_comb begin
    int unsigned nc;
    nc = 32'(scan_c_r) + 1;
    if (nc == 32'(req_r)) begin
      nc = nc + 1;
    end
    c_next    = CW'(nc);
    scan_last = (scan_b_r == BW'(BLOCKS_PER_CACHE - 1)) && (nc >= NUM_CACHES);
  end

  assign clr_last  = (clr_r == IDX_W'(NBLK - 1));
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign own_hit   = (rd.lstate != LS_I);
  // returning peer block holds the address in a valid state
  assign peer_hit  = chk_v_r && (op_r == OP_READ) && (rd.tag == addr_r)
                     && is_valid_state(rd.lstate);

  assign in_stall    = (state_r != ST_IDLE);
  assign out_valid   = out_valid_r;
  assign out_payload = out_payload_r;
  assign cfg_ready   = 1'b1;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_OWN;
        end
      end
      ST_OWN: begin
        if (op_r == OP_READ && own_hit) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (peer_hit) begin
          state_nxt = ST_FILL;
        end else if (chk_v_r && !issue_left_r) begin
          state_nxt = ST_DONE;
        end
      end
      ST_FILL: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // datapath, store port and result
  always_comb begin
    mode_nxt        = mode_r;
    clr_nxt         = clr_r;
    issue_left_nxt  = issue_left_r;
    chk_v_nxt       = 1'b0;
    out_valid_nxt   = out_valid_r;
    op_nxt          = op_r;
    addr_nxt        = addr_r;
    wdata_nxt       = wdata_r;
    mem_nxt         = mem_r;
    req_nxt         = req_r;
    me_nxt          = me_r;
    scan_c_nxt      = scan_c_r;
    scan_b_nxt      = scan_b_r;
    chk_idx_nxt     = chk_idx_r;
    chk_c_nxt       = chk_c_r;
    inval_nxt       = inval_r;
    pe_idx_nxt      = pe_idx_r;
    pe_entry_nxt    = pe_entry_r;
    res_nxt         = res_r;
    out_payload_nxt = out_payload_r;
    ram_we          = 1'b0;
    ram_waddr       = me_r;
    ram_wdata       = '0;
    ram_raddr       = me_r;

    if (cfg_valid && cfg_ready) begin
      mode_nxt = cfg_protocol_mode;
    end

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        clr_nxt   = clr_r + IDX_W'(1);
      end
      ST_IDLE: begin
        ram_raddr = me_now;
        if (in_accept) begin
          op_nxt         = in_payload.operation;
          addr_nxt       = in_payload.address;
          wdata_nxt      = in_payload.write_data;
          mem_nxt        = in_payload.memory_word;
          req_nxt        = req_now;
          me_nxt         = me_now;
          scan_c_nxt     = c_first;
          scan_b_nxt     = '0;
          issue_left_nxt = 1'b1;
          inval_nxt      = '0;
          res_nxt        = '0;
        end
      end
      ST_OWN: begin
        if (op_r == OP_READ) begin
          if (own_hit) begin
            res_nxt.read_data = rd.data;
            res_nxt.source    = SRC_LOCAL;
            res_nxt.new_state = rd.lstate;
          end
        end else begin
          // tag stays, data and state move
          ram_we             = 1'b1;
          ram_waddr          = me_r;
          ram_wdata.tag      = rd.tag;
          ram_wdata.data     = wdata_r;
          ram_wdata.lstate   = write_next(rd.lstate, mode_r);
          res_nxt.source     = SRC_WRITE;
          res_nxt.new_state  = write_next(rd.lstate, mode_r);
        end
      end
      ST_SCAN: begin
        // issue one peer read a cycle, check it the cycle after
        ram_raddr = peer_idx;
        if (issue_left_r) begin
          chk_v_nxt   = 1'b1;
          chk_idx_nxt = peer_idx;
          chk_c_nxt   = scan_c_r;
          if (scan_b_r == BW'(BLOCKS_PER_CACHE - 1)) begin
            scan_b_nxt = '0;
            scan_c_nxt = c_next;
          end else begin
            scan_b_nxt = scan_b_r + BW'(1);
          end
          if (scan_last) begin
            issue_left_nxt = 1'b0;
          end
        end
        if (chk_v_r) begin
          if (op_r == OP_WRITE) begin
            // every matching peer goes invalid, already invalid ones count too
            if (rd.tag == addr_r) begin
              ram_we           = 1'b1;
              ram_waddr        = chk_idx_r;
              ram_wdata.tag    = rd.tag;
              ram_wdata.data   = rd.data;
              ram_wdata.lstate = LS_I;
              if (inval_r != '1) begin
                inval_nxt = inval_r + INVAL_W'(1);
              end
            end
          end else if (peer_hit) begin
            ram_we               = 1'b1;
            ram_waddr            = me_r;
            ram_wdata.tag        = addr_r;
            ram_wdata.data       = rd.data;
            ram_wdata.lstate     = LS_S;
            pe_idx_nxt           = chk_idx_r;
            pe_entry_nxt.tag     = rd.tag;
            pe_entry_nxt.data    = rd.data;
            pe_entry_nxt.lstate  = peer_next(rd.lstate, mode_r);
            res_nxt.read_data    = rd.data;
            res_nxt.source       = SRC_PEER;
            res_nxt.source_cache = SRC_CACHE_W'(chk_c_r);
            res_nxt.new_state    = LS_S;
          end else if (!issue_left_r) begin
            // no peer holds it: fill from memory
            ram_we            = 1'b1;
            ram_waddr         = me_r;
            ram_wdata.tag     = addr_r;
            ram_wdata.data    = mem_r;
            ram_wdata.lstate  = LS_E;
            res_nxt.read_data = mem_r;
            res_nxt.source    = SRC_MEM;
            res_nxt.new_state = LS_E;
          end
        end
      end
      ST_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = pe_idx_r;
        ram_wdata = pe_entry_r;
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt               = 1'b1;
          out_payload_nxt             = res_r;
          out_payload_nxt.invalidated = inval_r;
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      mode_r       <= 1'b0;
      clr_r        <= '0;
      issue_left_r <= 1'b0;
      chk_v_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      mode_r       <= mode_nxt;
      clr_r        <= clr_nxt;
      issue_left_r <= issue_left_nxt;
      chk_v_r      <= chk_v_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r          <= op_nxt;
    addr_r        <= addr_nxt;
    wdata_r       <= wdata_nxt;
    mem_r         <= mem_nxt;
    req_r         <= req_nxt;
    me_r          <= me_nxt;
    scan_c_r      <= scan_c_nxt;
    scan_b_r      <= scan_b_nxt;
    chk_idx_r     <= chk_idx_nxt;
    chk_c_r       <= chk_c_nxt;
    inval_r       <= inval_nxt;
    pe_idx_r      <= pe_idx_nxt;
    pe_entry_r    <= pe_entry_nxt;
    res_r         <= res_nxt;
    out_payload_r <= out_payload_nxt;
  end

  // tag, data and line state of every block
  scbu_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NBLK)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // an accepted transaction always starts by looking at its own block
  `SCBU_ASSERT_NEXT(a_accept_to_own, in_accept, state_r == ST_OWN)
  // scan invalidations never hit the block being read in the same cycle
  `SCBU_ASSERT_NOW(a_scan_port_split, state_r == ST_SCAN && ram_we && issue_left_r,
                   ram_waddr != ram_raddr)
  // a result only appears out of the done state
  `SCBU_ASSERT_NOW(a_result_from_done, $rose(out_valid_r), $past(state_r == ST_DONE))
  // reads never report invalidations
  `SCBU_ASSERT_NOW(a_read_no_inval, state_r == ST_DONE && op_r == OP_READ, inval_r == '0)

endmodule

`default_nettype wire
